FILE: rtl/tft_pkg.sv
// ----------------------------------------------------------------------------
// tft_pkg: shared types and constants of the TCP flow tracker
// Packet and result layouts, the classified work item, and flag codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tft_pkg;

    localparam int FLOW_SLOTS_DEF = 64;

    // Exact flag patterns that select the connection handling.
    localparam logic [7:0] FLAG_SYN     = 8'h02;
    localparam logic [7:0] FLAG_SYN_ACK = 8'h12;

    // Fixed part of the IPv4 header in bytes.
    localparam logic [6:0] BASE_HDR_LEN = 7'd20;

    typedef enum logic [1:0] {
        OP_SYN,
        OP_SYN_ACK,
        OP_OTHER
    } op_t;

    typedef enum logic [1:0] {
        PH_EMPTY       = 2'd0,
        PH_SYN_SEEN    = 2'd1,
        PH_ESTABLISHED = 2'd2
    } phase_t;

    typedef logic [5:0] flow_slot_t;

    typedef struct packed {
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] ip_total_len;
        logic [3:0]  tcp_hdr_words;
        logic        has_payload;
        logic [31:0] ts_sec;
        logic [19:0] ts_usec;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic        new_flow;
        logic        table_full;
        flow_slot_t  flow_slot;
        logic        direction;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [7:0]  out_flags;
        logic [15:0] payload_len;
        logic [31:0] out_sec;
        logic [19:0] out_usec;
    } out_item_t;

    // Flow key in the direction of the opening SYN; ports is src high, dst low.
    typedef struct packed {
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [31:0] ports;
    } key_t;

    typedef struct packed {
        op_t         op;
        key_t        key;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  tcp_flags;
        logic [15:0] payload_len;
        logic [31:0] ts_sec;
        logic [19:0] ts_usec;
    } work_t;

endpackage

`default_nettype wire

FILE: rtl/tft_fifo.sv
// ----------------------------------------------------------------------------
// tft_fifo: two-entry queue
// Decouples two stages so that each side can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tft_front.sv
// ----------------------------------------------------------------------------
// tft_front: packet classifier
// Sorts each packet by its flags, forms the flow key and the payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_front (
    input  wire tft_pkg::in_item_t packet,
    input  wire logic              push,
    output logic                   full,
    output tft_pkg::work_t         work,
    output logic                   work_push,
    input  wire logic              work_full
);

    logic [6:0]  hdr_len;
    logic [15:0] len_diff;

    assign work_push = push;
    assign full      = work_full;

    always_comb
    begin
        // Header bytes: fixed IP part plus the TCP header in 32-bit words.
        hdr_len  = tft_pkg::BASE_HDR_LEN + {1'b0, packet.tcp_hdr_words, 2'b00};
        len_diff = packet.ip_total_len - {9'b0, hdr_len};

        if (packet.tcp_flags == tft_pkg::FLAG_SYN)
        begin
            work.op = tft_pkg::OP_SYN;
        end
        else if (packet.tcp_flags == tft_pkg::FLAG_SYN_ACK)
        begin
            work.op = tft_pkg::OP_SYN_ACK;
        end
        else
        begin
            work.op = tft_pkg::OP_OTHER;
        end

        work.key.ip_src   = packet.ip_src;
        work.key.ip_dst   = packet.ip_dst;
        work.key.ports    = {packet.src_port, packet.dst_port};
        work.seq_num      = packet.seq_num;
        work.ack_num      = packet.ack_num;
        work.tcp_flags    = packet.tcp_flags;
        work.ts_sec       = packet.ts_sec;
        work.ts_usec      = packet.ts_usec;

        // Short packets floor at zero rather than wrapping.
        if (packet.has_payload && (packet.ip_total_len > {9'b0, hdr_len}))
        begin
            work.payload_len = len_diff;
        end
        else
        begin
            work.payload_len = '0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tft_back.sv
// ----------------------------------------------------------------------------
// tft_back: flow table engine
// Scans the flow table one slot per cycle, then inserts or updates a flow.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_back #(
    parameter int FLOW_SLOTS = tft_pkg::FLOW_SLOTS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tft_pkg::work_t work,
    input  wire logic           work_empty,
    output logic                work_pop,
    output tft_pkg::out_item_t  res,
    output logic                res_push,
    input  wire logic           res_full
);

    localparam int IW = $clog2(FLOW_SLOTS);
    localparam int CW = $clog2(FLOW_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    // Flow table. Slots are filled from the bottom and never freed, so the
    // fill count alone tells which slots are occupied.
    tft_pkg::key_t   key_mem   [FLOW_SLOTS];
    tft_pkg::phase_t phase_mem [FLOW_SLOTS];

    state_t          state_reg,     state_next;
    logic [CW-1:0]   issue_idx_reg, issue_idx_next;
    logic            rd_vld_reg,    rd_vld_next;
    logic [IW-1:0]   rd_idx_reg;
    logic [CW-1:0]   count_reg,     count_next;
    logic            fwd_hit_reg,   fwd_hit_next;
    logic [IW-1:0]   fwd_slot_reg,  fwd_slot_next;
    tft_pkg::phase_t fwd_phase_reg, fwd_phase_next;
    logic            rev_hit_reg,   rev_hit_next;
    logic [IW-1:0]   rev_slot_reg,  rev_slot_next;
    tft_pkg::phase_t rev_phase_reg, rev_phase_next;

    tft_pkg::work_t  work_reg;
    tft_pkg::key_t   key_rd_reg;
    tft_pkg::phase_t phase_rd_reg;

    tft_pkg::key_t   rev_key;
    logic            issue;
    logic            fwd_match;
    logic            rev_match;
    logic            key_wr_en;
    logic            phase_wr_en;
    logic [IW-1:0]   phase_wr_idx;
    tft_pkg::phase_t phase_wr_data;
    logic            accept;
    logic            dir;
    logic            new_flow;
    logic            table_full;
    logic [IW-1:0]   slot;

    always_comb
    begin
        rev_key.ip_src = work_reg.key.ip_dst;
        rev_key.ip_dst = work_reg.key.ip_src;
        rev_key.ports  = {work_reg.key.ports[15:0], work_reg.key.ports[31:16]};
    end

    assign issue     = (state_reg == S_SCAN) && (issue_idx_reg < count_reg);
    assign fwd_match = rd_vld_reg && (key_rd_reg == work_reg.key);
    assign rev_match = rd_vld_reg && (key_rd_reg == rev_key);

    // Outcome of the finished scan.
    always_comb
    begin
        accept     = 1'b0;
        dir        = 1'b0;
        new_flow   = 1'b0;
        table_full = 1'b0;
        slot       = '0;
        case (work_reg.op)
            tft_pkg::OP_SYN:
            begin
                if (fwd_hit_reg)
                begin
                    accept = 1'b1;
                    slot   = fwd_slot_reg;
                end
                else if (count_reg < CW'(FLOW_SLOTS))
                begin
                    accept   = 1'b1;
                    new_flow = 1'b1;
                    slot     = count_reg[IW-1:0];
                end
                else
                begin
                    table_full = 1'b1;
                end
            end
            tft_pkg::OP_SYN_ACK:
            begin
                if (rev_hit_reg && (rev_phase_reg == tft_pkg::PH_SYN_SEEN))
                begin
                    accept = 1'b1;
                    dir    = 1'b1;
                    slot   = rev_slot_reg;
                end
            end
            tft_pkg::OP_OTHER:
            begin
                // The forward flow wins when both directions are established.
                if (fwd_hit_reg && (fwd_phase_reg == tft_pkg::PH_ESTABLISHED))
                begin
                    accept = 1'b1;
                    slot   = fwd_slot_reg;
                end
                else if (rev_hit_reg && (rev_phase_reg == tft_pkg::PH_ESTABLISHED))
                begin
                    accept = 1'b1;
                    dir    = 1'b1;
                    slot   = rev_slot_reg;
                end
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase

        res.accepted    = accept;
        res.new_flow    = new_flow;
        res.table_full  = table_full;
        res.flow_slot   = tft_pkg::flow_slot_t'(slot);
        res.direction   = dir;
        res.out_seq     = work_reg.seq_num;
        res.out_ack     = work_reg.ack_num;
        res.out_flags   = work_reg.tcp_flags;
        res.payload_len = work_reg.payload_len;
        res.out_sec     = work_reg.ts_sec;
        res.out_usec    = work_reg.ts_usec;
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        rd_vld_next    = 1'b0;
        count_next     = count_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_slot_next  = fwd_slot_reg;
        fwd_phase_next = fwd_phase_reg;
        rev_hit_next   = rev_hit_reg;
        rev_slot_next  = rev_slot_reg;
        rev_phase_next = rev_phase_reg;
        work_pop       = 1'b0;
        res_push       = 1'b0;
        key_wr_en      = 1'b0;
        phase_wr_en    = 1'b0;
        phase_wr_idx   = count_reg[IW-1:0];
        phase_wr_data  = tft_pkg::PH_SYN_SEEN;

        case (state_reg)
            S_IDLE:
            begin
                if (!work_empty)
                begin
                    work_pop       = 1'b1;
                    issue_idx_next = '0;
                    fwd_hit_next   = 1'b0;
                    rev_hit_next   = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_vld_next = issue;
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
                // Lowest matching slot wins: keep the first hit only.
                if (fwd_match && !fwd_hit_reg)
                begin
                    fwd_hit_next   = 1'b1;
                    fwd_slot_next  = rd_idx_reg;
                    fwd_phase_next = phase_rd_reg;
                end
                if (rev_match && !rev_hit_reg)
                begin
                    rev_hit_next   = 1'b1;
                    rev_slot_next  = rd_idx_reg;
                    rev_phase_next = phase_rd_reg;
                end
                if (!issue && !rd_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                    if (new_flow)
                    begin
                        key_wr_en   = 1'b1;
                        phase_wr_en = 1'b1;
                        count_next  = count_reg + CW'(1);
                    end
                    else if ((work_reg.op == tft_pkg::OP_SYN_ACK) && accept)
                    begin
                        phase_wr_en   = 1'b1;
                        phase_wr_idx  = rev_slot_reg;
                        phase_wr_data = tft_pkg::PH_ESTABLISHED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            count_reg     <= '0;
            fwd_hit_reg   <= 1'b0;
            fwd_slot_reg  <= '0;
            fwd_phase_reg <= tft_pkg::PH_EMPTY;
            rev_hit_reg   <= 1'b0;
            rev_slot_reg  <= '0;
            rev_phase_reg <= tft_pkg::PH_EMPTY;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= rd_vld_next;
            count_reg     <= count_next;
            fwd_hit_reg   <= fwd_hit_next;
            fwd_slot_reg  <= fwd_slot_next;
            fwd_phase_reg <= fwd_phase_next;
            rev_hit_reg   <= rev_hit_next;
            rev_slot_reg  <= rev_slot_next;
            rev_phase_reg <= rev_phase_next;
        end
    end

    // Payload registers and the table memories.
    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            work_reg <= work;
        end
        if (issue)
        begin
            key_rd_reg   <= key_mem[issue_idx_reg[IW-1:0]];
            phase_rd_reg <= phase_mem[issue_idx_reg[IW-1:0]];
            rd_idx_reg   <= issue_idx_reg[IW-1:0];
        end
        if (key_wr_en)
        begin
            key_mem[count_reg[IW-1:0]] <= work_reg.key;
        end
        if (phase_wr_en)
        begin
            phase_mem[phase_wr_idx] <= phase_wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcp_flow_tracker_top.sv
// A result is on the outputs once the engine has scanned every filled slot of the table (at
// most FLOW_SLOTS flows; none when the table is empty) and has written it into the result
// queue, which it does as soon as that queue has room. The engine takes one packet at a
// time and starts on the next only after that write; the table memory's single read port
// is scanned one slot a cycle. Reset clears all control state and empties the table at
// once via its fill count.
// ----------------------------------------------------------------------------
// tcp_flow_tracker_top: TCP connection tracker
// Classifies packets, looks them up in a flow table and streams one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_flow_tracker_top #(
    parameter int FLOW_SLOTS = tft_pkg::FLOW_SLOTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tft_pkg::in_item_t packet,
    input  wire logic              pop,
    output logic                   empty,
    output tft_pkg::out_item_t     result
);

    // The front end classifies a packet in the cycle of its transfer and
    // writes it into a short work queue. The table engine drains that queue
    // one packet at a time, so a burst of packets is absorbed while a scan
    // is still running.
    tft_pkg::work_t     work_in;
    tft_pkg::work_t     work_out;
    logic               work_push;
    logic               work_full;
    logic               work_pop;
    logic               work_empty;

    // Finished results wait in a second queue, so the engine can start on
    // the next packet while the consumer has not yet taken the last result.
    tft_pkg::out_item_t res;
    logic               res_push;
    logic               res_full;

    tft_front u_front (
        .packet    (packet),
        .push      (push),
        .full      (full),
        .work      (work_in),
        .work_push (work_push),
        .work_full (work_full)
    );

    tft_fifo #(
        .WIDTH ($bits(tft_pkg::work_t))
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_in),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (work_out),
        .empty (work_empty)
    );

    // The engine scans the table for the forward and reverse keys, then
    // inserts a new flow or advances its phase when the transfer of the
    // result into the output queue takes place.
    tft_back #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work_out),
        .work_empty (work_empty),
        .work_pop   (work_pop),
        .res        (res),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    tft_fifo #(
        .WIDTH ($bits(tft_pkg::out_item_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // A newly created flow is always an accepted packet.
    a_new_implies_accepted: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.new_flow) |-> (result.accepted && !result.table_full)
    ) else $error("new flow reported without acceptance");

    // Only a plain SYN can find the table full, and it is then dropped.
    a_full_only_on_syn: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.table_full) |->
            (!result.accepted && (result.out_flags == tft_pkg::FLAG_SYN))
    ) else $error("table full reported on a packet that was not dropped SYN");

    // A dropped packet carries no slot and no direction.
    a_drop_clears_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !result.accepted) |->
            ((result.flow_slot == '0) && !result.direction)
    ) else $error("dropped packet carries a slot or direction");

    // A SYN+ACK is only ever assigned in the responder direction.
    a_synack_direction: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.accepted && (result.out_flags == tft_pkg::FLAG_SYN_ACK))
            |-> result.direction
    ) else $error("SYN+ACK assigned in the initiator direction");

endmodule

`default_nettype wire
